// File: rtl/brc_pkg.sv
`default_nettype none

package brc_pkg;

   // Coordinate width of every request field and of every result field but visible
   localparam int COORD_BITS = 16;

   // Clip box registers
   localparam int CLIP_BITS  = 15;
   localparam int CSR_IDX_BITS = 4;
   localparam int CSR_DATA_BITS = 16;

   localparam logic [CLIP_BITS-1:0] CLIP_LO_RESET = '0;
   localparam logic [CLIP_BITS-1:0] CLIP_HI_RESET = '1;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_DST_CLIP_X0 = 4'd0,
      CSR_DST_CLIP_Y0 = 4'd1,
      CSR_DST_CLIP_X1 = 4'd2,
      CSR_DST_CLIP_Y1 = 4'd3,
      CSR_SRC_CLIP_X0 = 4'd4,
      CSR_SRC_CLIP_Y0 = 4'd5,
      CSR_SRC_CLIP_X1 = 4'd6,
      CSR_SRC_CLIP_Y1 = 4'd7
   } csr_index_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] dest_x;
      logic signed [COORD_BITS-1:0] dest_y;
      logic signed [COORD_BITS-1:0] source_x;
      logic signed [COORD_BITS-1:0] source_y;
      logic signed [COORD_BITS-1:0] rect_width;
      logic signed [COORD_BITS-1:0] rect_height;
   } req_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] out_dest_x;
      logic signed [COORD_BITS-1:0] out_dest_y;
      logic signed [COORD_BITS-1:0] out_source_x;
      logic signed [COORD_BITS-1:0] out_source_y;
      logic signed [COORD_BITS-1:0] out_width;
      logic signed [COORD_BITS-1:0] out_height;
      logic                         visible;
   } rsp_type;

endpackage

`default_nettype wire

// File: rtl/blit_rect_clipper_core.sv
`default_nettype none

// Blit rectangle clipper.
// A request (destination position, source rectangle and size) is taken on
// req_data at a rising edge with start high and busy low. busy is always low:
// a new request may be issued in every cycle.
// Each request is tested for overlap against the destination and source clip
// boxes, then trimmed edge by edge; the clipped request and a visible flag
// come out on rsp_data, marked by a one-cycle rsp_valid strobe.
// rsp_valid is registered: a request passes the input register, then the result
// register; throughput is one request per cycle, set by the single combinational
// trim chain between the two registers.
// When nothing is left to draw, visible is 0 and all coordinates are 0.
// Clip boxes are written over the csr_ port (always ready); index 0..7
// selects dst x0, y0, x1, y1 then src x0, y0, x1, y1, only the low 15 bits
// are kept and other indexes are ignored. Write only while no request is
// in flight.
// Reset (synchronous) drops any request in flight and sets the clip boxes
// to the full 0..32767 range.
// The receiver cannot stall: every result is presented for exactly one cycle.
module blit_rect_clipper_core (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    start,
   output logic                                   busy,
   input  wire brc_pkg::req_type                  req_data,
   output logic                                   rsp_valid,
   output brc_pkg::rsp_type                       rsp_data,
   input  wire                                    csr_valid,
   output logic                                   csr_ready,
   input  wire [brc_pkg::CSR_IDX_BITS-1:0]        csr_index,
   input  wire [brc_pkg::CSR_DATA_BITS-1:0]       csr_data
);

   localparam int CB = brc_pkg::COORD_BITS;
   localparam int KB = brc_pkg::CLIP_BITS;
   // wide enough for exact position + size and for any clip value
   localparam int EB = ((CB > KB) ? CB : KB) + 2;

   typedef logic signed [CB-1:0] coord_type;
   typedef logic signed [EB-1:0] wide_type;

   // clip box registers
   logic [KB-1:0] dcx0_ff, dcy0_ff, dcx1_ff, dcy1_ff;
   logic [KB-1:0] scx0_ff, scy0_ff, scx1_ff, scy1_ff;
   logic [KB-1:0] csr_val;

   // pipeline registers
   logic             req_valid_ff;
   brc_pkg::req_type req_ff;
   logic             rsp_valid_ff;
   brc_pkg::rsp_type rsp_ff, rsp_in;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign csr_val   = csr_data[KB-1:0];

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         dcx0_ff <= brc_pkg::CLIP_LO_RESET;
         dcy0_ff <= brc_pkg::CLIP_LO_RESET;
         dcx1_ff <= brc_pkg::CLIP_HI_RESET;
         dcy1_ff <= brc_pkg::CLIP_HI_RESET;
         scx0_ff <= brc_pkg::CLIP_LO_RESET;
         scy0_ff <= brc_pkg::CLIP_LO_RESET;
         scx1_ff <= brc_pkg::CLIP_HI_RESET;
         scy1_ff <= brc_pkg::CLIP_HI_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            brc_pkg::CSR_DST_CLIP_X0: dcx0_ff <= csr_val;
            brc_pkg::CSR_DST_CLIP_Y0: dcy0_ff <= csr_val;
            brc_pkg::CSR_DST_CLIP_X1: dcx1_ff <= csr_val;
            brc_pkg::CSR_DST_CLIP_Y1: dcy1_ff <= csr_val;
            brc_pkg::CSR_SRC_CLIP_X0: scx0_ff <= csr_val;
            brc_pkg::CSR_SRC_CLIP_Y0: scy0_ff <= csr_val;
            brc_pkg::CSR_SRC_CLIP_X1: scx1_ff <= csr_val;
            brc_pkg::CSR_SRC_CLIP_Y1: scy1_ff <= csr_val;
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         req_ff <= req_data;
      end
   end

   // positive test on a wrapped difference
   function automatic logic is_pos(input coord_type v);
      return !v[CB-1] && (v != '0);
   endfunction

   // clip value as a coordinate (wraps when coordinates are narrow)
   function automatic coord_type clip_c(input logic [KB-1:0] c);
      return coord_type'(c);
   endfunction

   // clip value at overlap-test width
   function automatic wide_type clip_w(input logic [KB-1:0] c);
      return wide_type'($signed({1'b0, c}));
   endfunction

   // overlap test and trim chain
   always_comb begin
      coord_type dx, dy, sx, sy, w, h, d;
      wide_type  edx, edy, esx, esy, ew, eh;
      logic      hit;

      dx = req_ff.dest_x;
      dy = req_ff.dest_y;
      sx = req_ff.source_x;
      sy = req_ff.source_y;
      w  = req_ff.rect_width;
      h  = req_ff.rect_height;

      edx = wide_type'(dx);
      edy = wide_type'(dy);
      esx = wide_type'(sx);
      esy = wide_type'(sy);
      ew  = wide_type'(w);
      eh  = wide_type'(h);

      hit = (edx < clip_w(dcx1_ff)) && (edy < clip_w(dcy1_ff)) &&
            (edx + ew > clip_w(dcx0_ff)) && (edy + eh > clip_w(dcy0_ff)) &&
            (esx < clip_w(scx1_ff)) && (esy < clip_w(scy1_ff)) &&
            (esx + ew > clip_w(scx0_ff)) && (esy + eh > clip_w(scy0_ff));

      // destination left
      d = clip_c(dcx0_ff) - dx;
      if (is_pos(d)) begin
         w  = w - d;
         sx = sx + d;
         dx = clip_c(dcx0_ff);
      end
      // source left
      d = clip_c(scx0_ff) - sx;
      if (is_pos(d)) begin
         w  = w - d;
         dx = dx + d;
         sx = clip_c(scx0_ff);
      end
      // destination top
      d = clip_c(dcy0_ff) - dy;
      if (is_pos(d)) begin
         h  = h - d;
         sy = sy + d;
         dy = clip_c(dcy0_ff);
      end
      // source top
      d = clip_c(scy0_ff) - sy;
      if (is_pos(d)) begin
         h  = h - d;
         dy = dy + d;
         sy = clip_c(scy0_ff);
      end
      // source right and bottom
      d = sx + w - clip_c(scx1_ff);
      if (is_pos(d)) begin
         w = w - d;
      end
      d = sy + h - clip_c(scy1_ff);
      if (is_pos(d)) begin
         h = h - d;
      end
      // destination right and bottom
      d = dx + w - clip_c(dcx1_ff);
      if (is_pos(d)) begin
         w = w - d;
      end
      d = dy + h - clip_c(dcy1_ff);
      if (is_pos(d)) begin
         h = h - d;
      end

      rsp_in = '0;
      if (hit && is_pos(w) && is_pos(h)) begin
         rsp_in.out_dest_x   = dx;
         rsp_in.out_dest_y   = dy;
         rsp_in.out_source_x = sx;
         rsp_in.out_source_y = sy;
         rsp_in.out_width    = w;
         rsp_in.out_height   = h;
         rsp_in.visible      = 1'b1;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// File: tb/sv/tb_clip_pkg.sv
package tb_clip_pkg;
   import brc_pkg::*;

   // Clip prediction and result checking for the blit clipper
   class blit_clip_scoreboard;
      logic [CLIP_BITS-1:0] dst_x0, dst_y0, dst_x1, dst_y1;
      logic [CLIP_BITS-1:0] src_x0, src_y0, src_x1, src_y1;
      rsp_type              expected_clips[$];
      int                   errors;

      function new();
         dst_x0 = CLIP_LO_RESET;
         dst_y0 = CLIP_LO_RESET;
         dst_x1 = CLIP_HI_RESET;
         dst_y1 = CLIP_HI_RESET;
         src_x0 = CLIP_LO_RESET;
         src_y0 = CLIP_LO_RESET;
         src_x1 = CLIP_HI_RESET;
         src_y1 = CLIP_HI_RESET;
         errors = 0;
      endfunction

      // Two's complement wrap to the coordinate width
      static function longint wrap(longint v);
         logic signed [COORD_BITS-1:0] t;
         t = v[COORD_BITS-1:0];
         return t;
      endfunction

      // Clip box write; unknown indexes are dropped, bit 15 is discarded
      function void write_clip(logic [CSR_IDX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] data);
         case (csr_index_type'(idx))
            CSR_DST_CLIP_X0: dst_x0 = data[CLIP_BITS-1:0];
            CSR_DST_CLIP_Y0: dst_y0 = data[CLIP_BITS-1:0];
            CSR_DST_CLIP_X1: dst_x1 = data[CLIP_BITS-1:0];
            CSR_DST_CLIP_Y1: dst_y1 = data[CLIP_BITS-1:0];
            CSR_SRC_CLIP_X0: src_x0 = data[CLIP_BITS-1:0];
            CSR_SRC_CLIP_Y0: src_y0 = data[CLIP_BITS-1:0];
            CSR_SRC_CLIP_X1: src_x1 = data[CLIP_BITS-1:0];
            CSR_SRC_CLIP_Y1: src_y1 = data[CLIP_BITS-1:0];
            default: ;
         endcase
      endfunction

      // Overlap test on exact sums, then the eight trims in fixed order
      function rsp_type clip_blit(req_type r);
         longint dx, dy, sx, sy, w, h, d;
         longint dl, dt, dr, db, sl, st, sr, sb;
         rsp_type res;
         bit vis;
         dx = wrap(r.dest_x);
         dy = wrap(r.dest_y);
         sx = wrap(r.source_x);
         sy = wrap(r.source_y);
         w  = wrap(r.rect_width);
         h  = wrap(r.rect_height);
         dl = dst_x0; dt = dst_y0; dr = dst_x1; db = dst_y1;
         sl = src_x0; st = src_y0; sr = src_x1; sb = src_y1;
         vis = 1'b0;
         res = '0;
         if (dx < dr && dy < db && dx + w > dl && dy + h > dt &&
             sx < sr && sy < sb && sx + w > sl && sy + h > st) begin
            d = wrap(dl - dx);
            if (d > 0) begin
               w = wrap(w - d); sx = wrap(sx + d); dx = dl;
            end
            d = wrap(sl - sx);
            if (d > 0) begin
               w = wrap(w - d); dx = wrap(dx + d); sx = sl;
            end
            d = wrap(dt - dy);
            if (d > 0) begin
               h = wrap(h - d); sy = wrap(sy + d); dy = dt;
            end
            d = wrap(st - sy);
            if (d > 0) begin
               h = wrap(h - d); dy = wrap(dy + d); sy = st;
            end
            d = wrap(sx + w - sr);
            if (d > 0) w = wrap(w - d);
            d = wrap(sy + h - sb);
            if (d > 0) h = wrap(h - d);
            d = wrap(dx + w - dr);
            if (d > 0) w = wrap(w - d);
            d = wrap(dy + h - db);
            if (d > 0) h = wrap(h - d);
            vis = (w > 0) && (h > 0);
         end
         if (vis) begin
            res.out_dest_x   = dx[COORD_BITS-1:0];
            res.out_dest_y   = dy[COORD_BITS-1:0];
            res.out_source_x = sx[COORD_BITS-1:0];
            res.out_source_y = sy[COORD_BITS-1:0];
            res.out_width    = w[COORD_BITS-1:0];
            res.out_height   = h[COORD_BITS-1:0];
            res.visible      = 1'b1;
         end
         return res;
      endfunction

      function void note_request(req_type r);
         expected_clips.push_back(clip_blit(r));
      endfunction

      function int pending();
         return expected_clips.size();
      endfunction

      task report(string what);
         $display("%0t ns: clip mismatch: %s", $time, what);
         errors++;
      endtask

      task check_field(string name, logic [COORD_BITS-1:0] got, logic [COORD_BITS-1:0] want);
         if (got !== want)
            report($sformatf("%s got %0d expected %0d", name,
                             $signed(got), $signed(want)));
      endtask

      // Compare one result transaction against the oldest prediction
      task check_result(rsp_type got);
         rsp_type want;
         if (expected_clips.size() == 0) begin
            report("result with no request outstanding");
         end else begin
            want = expected_clips.pop_front();
            check_field("out_dest_x", got.out_dest_x, want.out_dest_x);
            check_field("out_dest_y", got.out_dest_y, want.out_dest_y);
            check_field("out_source_x", got.out_source_x, want.out_source_x);
            check_field("out_source_y", got.out_source_y, want.out_source_y);
            check_field("out_width", got.out_width, want.out_width);
            check_field("out_height", got.out_height, want.out_height);
            if (got.visible !== want.visible)
               report($sformatf("visible got %0b expected %0b", got.visible, want.visible));
         end
      endtask
   endclass

endpackage

// File: tb/sv/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import brc_pkg::*;
   import tb_clip_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASES = 8;
   localparam int ITEMS_PER_PHASE = 170;
   localparam csr_index_type CLIP_REGS [8] = '{
      CSR_DST_CLIP_X0, CSR_DST_CLIP_Y0, CSR_DST_CLIP_X1, CSR_DST_CLIP_Y1,
      CSR_SRC_CLIP_X0, CSR_SRC_CLIP_Y0, CSR_SRC_CLIP_X1, CSR_SRC_CLIP_Y1
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_data = '0;
   logic rsp_valid;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_data = '0;

   blit_rect_clipper_core dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   blit_clip_scoreboard sb;
   int clip_cfg[8];   // same order as CLIP_REGS
   int cycle_count = 0;

   always #10 clock = ~clock;

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

   // Monitor: results, accepted requests and clip writes, all sampled at the edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) sb.check_result(rsp_data);
         if (start && !busy) sb.note_request(req_data);
         if (csr_valid && csr_ready) sb.write_clip(csr_index, csr_data);
      end
   end

   task automatic wait_drained();
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // Issue one request transaction; start stays high across back-to-back items
   task automatic send_request(input req_type r, input int gap, input bit pause);
      if (gap > 0 || pause) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
         if (pause) wait_drained();
      end
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
   endtask

   task automatic send_coords(input int dx, input int dy, input int sx, input int sy,
                              input int w, input int h);
      req_type r;
      r.dest_x      = 16'(dx);
      r.dest_y      = 16'(dy);
      r.source_x    = 16'(sx);
      r.source_y    = 16'(sy);
      r.rect_width  = 16'(w);
      r.rect_height = 16'(h);
      send_request(r, $urandom_range(0, 17), 1'b0);
   endtask

   // Write all clip registers from clip_cfg, plus one write to an unused index
   task automatic set_boxes();
      for (int i = 0; i < 8; i++) begin
         csr_valid <= 1'b1;
         csr_index <= CLIP_REGS[i];
         csr_data  <= {1'($urandom_range(0, 1)), 15'(clip_cfg[i])};
         do @(posedge clock); while (!csr_ready);
      end
      csr_index <= CSR_IDX_BITS'($urandom_range(int'(CSR_SRC_CLIP_Y1) + 1,
                                                (1 << CSR_IDX_BITS) - 1));
      csr_data  <= 16'($urandom);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Coordinate near either edge of a box, or anywhere inside
   function automatic int near_edge(int lo, int hi);
      int base;
      case ($urandom_range(0, 3))
         0: base = lo;
         1: base = hi;
         default: base = $urandom_range(lo, hi);
      endcase
      return base + $urandom_range(0, 96) - 48;
   endfunction

   function automatic int rand_size();
      if ($urandom_range(0, 9) == 0) return $urandom_range(0, 65535);
      return $urandom_range(0, 160) - 16;
   endfunction

   // Mostly requests aimed at the current boxes, some pure noise
   function automatic req_type random_request();
      req_type r;
      if ($urandom_range(0, 7) == 0) begin
         r = {$urandom, $urandom, $urandom};
      end else begin
         r.dest_x      = 16'(near_edge(clip_cfg[0], clip_cfg[2]));
         r.dest_y      = 16'(near_edge(clip_cfg[1], clip_cfg[3]));
         r.source_x    = 16'(near_edge(clip_cfg[4], clip_cfg[6]));
         r.source_y    = 16'(near_edge(clip_cfg[5], clip_cfg[7]));
         r.rect_width  = 16'(rand_size());
         r.rect_height = 16'(rand_size());
      end
      return r;
   endfunction

   initial begin
      bit burst;
      int lo;
      int gap;
      sb = new();
      for (int i = 0; i < 8; i++) clip_cfg[i] = (i % 4 < 2) ? 0 : 32767;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed requests under the reset clip boxes
      send_coords(0, 0, 0, 0, 0, 0);
      send_coords(10, 20, 5, 6, 30, 40);
      send_coords(-5, 3, 7, 8, 20, 20);          // destination left trim
      send_coords(4, 3, -7, 8, 20, 20);          // source left trim
      send_coords(4, -3, 7, 8, 20, 20);          // destination top trim
      send_coords(4, 3, 7, -9, 20, 20);          // source top trim
      send_coords(4, 3, 32760, 8, 20, 20);       // source right trim
      send_coords(4, 3, 7, 32760, 20, 20);       // source bottom trim
      send_coords(32760, 3, 7, 8, 20, 20);       // destination right trim
      send_coords(4, 32760, 7, 8, 20, 20);       // destination bottom trim
      send_coords(-10, -10, -10, -10, 30, 30);   // destination left/top trims (source sides then already inside)
      send_coords(0, 0, 0, 0, 32767, 32767);
      send_coords(32767, 32767, 32767, 32767, 32767, 32767);
      send_coords(-32768, -32768, -32768, -32768, -32768, -32768);
      send_coords(-20000, 0, 20000, 0, 32767, 10); // trims that wrap
      send_coords(32000, 0, 0, 0, 1000, 10);       // overlap sum beyond range
      send_coords(0, 0, 0, 0, -1, 5);              // negative width
      send_coords(-1, 0, 0, 0, 1, 1);              // touches the left edge only
      send_coords(32766, 32766, 0, 0, 1, 1);
      send_coords(21845, -21846, 10922, -10923, -21846, 21845);
      send_coords(-1, -1, -1, -1, -1, -1);

      // Random phases, each under its own clip boxes
      for (int p = 0; p < PHASES; p++) begin
         start <= 1'b0;
         wait_drained();
         for (int k = 0; k < 4; k++) begin
            lo = (k / 2) * 4 + (k % 2);
            case (p)
               0: begin clip_cfg[lo] = 0;     clip_cfg[lo + 2] = 32767; end
               1: begin clip_cfg[lo] = 32767; clip_cfg[lo + 2] = 32767; end
               2: begin clip_cfg[lo] = 0;     clip_cfg[lo + 2] = 0;     end
               3: begin
                  // inverted boxes
                  clip_cfg[lo]     = $urandom_range(16384, 32767);
                  clip_cfg[lo + 2] = $urandom_range(0, 16383);
               end
               default: begin
                  clip_cfg[lo] = (p == PHASES - 1) ? $urandom_range(32500, 32767)
                                                   : $urandom_range(0, 32767);
                  clip_cfg[lo + 2] = clip_cfg[lo] + $urandom_range(0, 300);
                  if (clip_cfg[lo + 2] > 32767) clip_cfg[lo + 2] = 32767;
               end
            endcase
         end
         set_boxes();
         burst = 1'b0;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (n % 32 == 0) burst = ($urandom_range(0, 3) == 0);
            gap = burst ? 0 : $urandom_range(0, 17);
            send_request(random_request(), gap, $urandom_range(0, 63) == 0);
         end
      end

      // Let the pipeline empty, then a short tail
      start <= 1'b0;
      wait_drained();
      repeat (4) @(posedge clock);
      if (sb.pending() != 0) sb.report("expected results never arrived");
      if (sb.errors == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/brc_pkg.sv
rtl/blit_rect_clipper_core.sv
tb/sv/tb_clip_pkg.sv
tb/sv/tb_top.sv
